@@ rtl/core/revol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revol_pkg
// shared constants and types for the range spread volatility block
// ----------------------------------------------------------------------------
package revol_pkg;

	localparam int ShortSpanDef = 10;
	localparam int LongSpanDef  = 20;

	localparam logic [15:0] ShortSmoothRst = 16'd11916;
	localparam logic [15:0] LongSmoothRst  = 16'd6242;

	localparam int RangeW = 33;
	// average in Q33.8: range times 256
	localparam int AvgW   = RangeW + 8;
	// numerator 100 * |diff|
	localparam int NumW   = AvgW + 8;
	localparam int QuoW   = NumW + 16;

	localparam logic CfgShort = 1'b0;
	localparam logic CfgLong  = 1'b1;

	typedef struct packed {
		logic load;
		logic init_avg;
		logic step_long;
		logic div_start;
	} revol_cmd_t;

	typedef struct packed {
		logic line_full;
		logic div_done;
	} revol_sts_t;

endpackage

@@ rtl/core/revol_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revol_in_if / revol_out_if
// valid/ready channels for price pairs and volatility results
// ----------------------------------------------------------------------------
interface revol_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] high_price;
	logic [31:0] low_price;
	modport source (output valid, high_price, low_price, input ready);
	modport sink (input valid, high_price, low_price, output ready);
endinterface

interface revol_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] volatility_percent;
	logic               divide_by_zero;
	logic               saturated;
	modport source (output valid, volatility_percent, divide_by_zero, saturated,
		input ready);
	modport sink (input valid, volatility_percent, divide_by_zero, saturated,
		output ready);
endinterface

@@ rtl/core/revol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revol_ctrl
// sequencer: line update, two average recursions, divide, result handoff
// ----------------------------------------------------------------------------
module revol_ctrl
	import revol_pkg::*;
#(
	parameter int LineDepth = LongSpanDef - 1,
	parameter int CntW = $clog2(LineDepth + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  revol_sts_t        sts,
	output revol_cmd_t        cmd,
	output logic [CntW-1:0]   idx
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_LONG  = 6'b000100,
		ST_SHORT = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign idx       = cnt_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE:  cmd.init_avg = 1'b0;
			ST_INIT:  cmd.init_avg = 1'b1;
			ST_LONG:  cmd.step_long = 1'b1;
			ST_SHORT: cmd.div_start = 1'b0;
			ST_DIV:   cmd.div_start = 1'b0;
			ST_WAIT:  cmd.div_start = 1'b0;
			default:  cmd.init_avg = 1'b0;
		endcase
		cmd.div_start = (state_q == ST_SHORT) && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// line updated; decide whether a result is due
					if (sts.line_full) begin
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					cnt_q   <= CntW'(LineDepth - 1);
					state_q <= ST_LONG;
				end
				ST_LONG: begin
					// long and short step in parallel; long starts first and both end at index zero
					if (cnt_q == '0) begin
						cnt_q   <= '0;
						state_q <= ST_SHORT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SHORT: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/revol_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revol_dp
// range line, shared-step ema recursions and restoring divider
// ----------------------------------------------------------------------------
module revol_dp
	import revol_pkg::*;
#(
	parameter int LineDepth = LongSpanDef - 1,
	parameter int ShortDepth = ShortSpanDef - 1,
	parameter int CntW = $clog2(LineDepth + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  revol_cmd_t         cmd,
	input  logic [CntW-1:0]    idx,
	input  logic [31:0]        high_price,
	input  logic [31:0]        low_price,
	input  logic [15:0]        short_smoothing,
	input  logic [15:0]        long_smoothing,
	output revol_sts_t         sts,
	output logic signed [31:0] volatility_percent,
	output logic               divide_by_zero,
	output logic               saturated
);

	localparam int IdxW = (LineDepth > 1) ? $clog2(LineDepth) : 1;

	logic signed [RangeW-1:0] line_q [LineDepth];
	logic [CntW-1:0]          fill_q;
	logic signed [AvgW-1:0]   s_avg_q, l_avg_q;
	logic                     div_done_q;

	// line shift and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < LineDepth; i++) line_q[i] <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < LineDepth - 1; i++) line_q[i] <= line_q[i+1];
			line_q[LineDepth-1] <= $signed({1'b0, high_price}) - $signed({1'b0, low_price});
			if (fill_q < CntW'(LineDepth)) fill_q <= fill_q + 1'b1;
		end
	end
	assign sts.line_full = (fill_q == CntW'(LineDepth));
	assign sts.div_done  = div_done_q;

	// one ema step: avg + round(s*(x-avg)/65536), halves up
	function automatic logic signed [AvgW-1:0] ema_step(
		input logic signed [AvgW-1:0] avg,
		input logic signed [RangeW-1:0] x,
		input logic [15:0] s);
		logic signed [AvgW:0]    d;
		logic signed [AvgW+17:0] p;
		begin
			d = $signed({x, 8'd0}) - (AvgW+1)'(avg);
			p = d * $signed({1'b0, s});
			p = p + (AvgW+18)'(32768);
			ema_step = avg + AvgW'(p >>> 16);
		end
	endfunction

	logic [IdxW-1:0] ix;
	assign ix = idx[IdxW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.init_avg) begin
			l_avg_q <= $signed({line_q[LineDepth-1], 8'd0});
			s_avg_q <= $signed({line_q[ShortDepth-1], 8'd0});
		end else if (cmd.step_long) begin
			l_avg_q <= ema_step(l_avg_q, line_q[ix], long_smoothing);
			if (idx < CntW'(ShortDepth))
				s_avg_q <= ema_step(s_avg_q, line_q[ix], short_smoothing);
		end
	end

	// divider: 100*65536*|S-L| / |L|, one quotient bit a cycle
	logic signed [AvgW:0] diff;
	logic [NumW-1:0]      num;
	logic [AvgW-1:0]      den_q;
	logic [QuoW-1:0]      dvd_q, quo_q;
	logic [AvgW:0]        rem_q;
	logic [6:0]           bit_q;
	logic                 busy_q, neg_q, zero_q;
	logic [AvgW:0]        trial;

	assign diff  = (AvgW+1)'(s_avg_q) - (AvgW+1)'(l_avg_q);
	assign num   = NumW'((diff < 0) ? -diff : diff) * NumW'(100);
	assign trial = {rem_q[AvgW-1:0], dvd_q[QuoW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				busy_q     <= (l_avg_q != '0);
				div_done_q <= (l_avg_q == '0);
				zero_q <= (l_avg_q == '0);
				neg_q  <= (diff < 0) != (l_avg_q < 0);
				den_q  <= (l_avg_q < 0) ? AvgW'(-l_avg_q) : AvgW'(l_avg_q);
				dvd_q  <= {num, 16'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				bit_q  <= 7'(QuoW);
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[QuoW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[QuoW-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
				if (bit_q == 7'd1) begin
					busy_q     <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	// saturate and apply sign
	logic pos_ovf, neg_ovf;
	assign pos_ovf = !neg_q && (quo_q > QuoW'(32'h7FFFFFFF));
	assign neg_ovf = neg_q && (quo_q > QuoW'(32'h80000000));

	always_ff @(posedge clk) begin
		if (div_done_q) begin
			if (zero_q) begin
				volatility_percent <= '0;
				divide_by_zero     <= 1'b1;
				saturated          <= 1'b0;
			end else begin
				divide_by_zero <= 1'b0;
				saturated      <= pos_ovf || neg_ovf;
				if (pos_ovf) volatility_percent <= 32'sh7FFFFFFF;
				else if (neg_ovf) volatility_percent <= 32'sh80000000;
				else if (neg_q) volatility_percent <= 32'(-quo_q[31:0]);
				else volatility_percent <= quo_q[31:0];
			end
		end
	end

endmodule

@@ rtl/core/range_ema_spread_volatility.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_ema_spread_volatility
// chaikin style volatility from high/low pairs, fixed point
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   high_price, low_price
// out_ch   out  volatility_percent, divide_by_zero, saturated
// cfg      in   cfg_we, cfg_index, cfg_data
//
// an item that yields no result passes from idle through the wait state back to
// idle; with a full line the block then seeds and runs the two averages and
// runs the divider before the result is valid
// the restoring divider, one quotient bit a cycle, sets most of the latency
// reset clears the range line and fill count at once
// the next transaction is taken only after the result has been taken
// ----------------------------------------------------------------------------
module range_ema_spread_volatility
	import revol_pkg::*;
#(
	parameter int SHORT_SPAN = ShortSpanDef,
	parameter int LONG_SPAN  = LongSpanDef
) (
	input  logic        clk,
	input  logic        arst_n,
	revol_in_if.sink    in_ch,
	revol_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LineDepth  = LONG_SPAN - 1;
	localparam int ShortDepth = (SHORT_SPAN < LONG_SPAN) ? SHORT_SPAN - 1 : LONG_SPAN - 1;
	localparam int CntW       = $clog2(LineDepth + 1);

	logic [15:0]     short_q, long_q;
	revol_cmd_t      cmd;
	revol_sts_t      sts;
	logic [CntW-1:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= ShortSmoothRst;
			long_q  <= LongSmoothRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgShort: short_q <= cfg_data;
				CfgLong:  long_q  <= cfg_data;
				default:  short_q <= short_q;
			endcase
		end
	end

	revol_ctrl #(.LineDepth(LineDepth), .CntW(CntW)) u_ctrl (
		.clk, .arst_n,
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts, .cmd, .idx
	);

	revol_dp #(.LineDepth(LineDepth), .ShortDepth(ShortDepth), .CntW(CntW)) u_dp (
		.clk, .arst_n, .cmd, .idx,
		.high_price        (in_ch.high_price),
		.low_price         (in_ch.low_price),
		.short_smoothing   (short_q),
		.long_smoothing    (long_q),
		.sts,
		.volatility_percent(out_ch.volatility_percent),
		.divide_by_zero    (out_ch.divide_by_zero),
		.saturated         (out_ch.saturated)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.divide_by_zero && out_ch.saturated))
		else $error("both flags set");
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.divide_by_zero) |-> (out_ch.volatility_percent == 0))
		else $error("nonzero result on divide by zero");
`endif

endmodule
